/* rtl/dd_odo_pkg.sv */
// ----------------------------------------------------------------------------
// dd_odo_pkg
// Shared types, constants and small functions for the differential-drive
// odometry block.
// ----------------------------------------------------------------------------
package dd_odo_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ELAPSED_W = 18;
    localparam int unsigned HEAD_W    = 16;
    localparam int unsigned MUL_W     = 34;
    localparam int unsigned PROD_W    = 2 * MUL_W;
    localparam int unsigned KACC_W    = 80;
    localparam int unsigned ATAN_LEN  = 24;

    // action codes
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_SPEEDS  = 2'd1;
    localparam logic [1:0] ACT_VECTORS = 2'd2;

    // cordic start value and radian to binary-angle factor
    localparam logic signed [MUL_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic signed [MUL_W-1:0] RAD_TO_BAM  = 34'sh028BE60DC;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] left_speed;
        logic signed [31:0] right_speed;
        logic signed [31:0] left_vx;
        logic signed [31:0] left_vy;
        logic signed [31:0] right_vx;
        logic signed [31:0] right_vy;
        logic [17:0]        elapsed;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] x_position;
        logic signed [31:0] y_position;
        logic [15:0]        heading;
        logic signed [31:0] x_rate;
        logic signed [31:0] y_rate;
        logic signed [31:0] turn_rate;
        logic [31:0]        sequence_res;
        logic               separation_error;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_VEC_SQX,
        S_VEC_SQY,
        S_VEC_DOTX,
        S_VEC_DOTY,
        S_VEC_ROOT,
        S_VEC_WAIT,
        S_TICK_START,
        S_TICK_WAIT,
        S_MUL_VC,
        S_MUL_VS,
        S_MUL_XE,
        S_MUL_YE,
        S_MUL_TE,
        S_MUL_KL,
        S_MUL_KH,
        S_HEAD,
        S_EMIT
    } seq_state_t;

    // arctangent of 2^-i as a 32-bit binary angle
    function automatic logic [29:0] atan_at(input logic [4:0] idx);
        logic [29:0] val;
        case (idx)
            5'd0:    val = 30'h20000000;
            5'd1:    val = 30'h12E4051E;
            5'd2:    val = 30'h09FB385B;
            5'd3:    val = 30'h051111D4;
            5'd4:    val = 30'h028B0D43;
            5'd5:    val = 30'h0145D7E1;
            5'd6:    val = 30'h00A2F61E;
            5'd7:    val = 30'h00517C55;
            5'd8:    val = 30'h0028BE53;
            5'd9:    val = 30'h00145F2F;
            5'd10:   val = 30'h000A2F98;
            5'd11:   val = 30'h000517CC;
            5'd12:   val = 30'h00028BE6;
            5'd13:   val = 30'h000145F3;
            5'd14:   val = 30'h0000A2FA;
            5'd15:   val = 30'h0000517D;
            5'd16:   val = 30'h000028BE;
            5'd17:   val = 30'h0000145F;
            5'd18:   val = 30'h00000A30;
            5'd19:   val = 30'h00000518;
            5'd20:   val = 30'h0000028C;
            5'd21:   val = 30'h00000146;
            5'd22:   val = 30'h000000A3;
            5'd23:   val = 30'h00000051;
            default: val = 30'h0;
        endcase
        return val;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [KACC_W-1:0] val);
        logic signed [31:0] res;
        if (val > 80'sd2147483647)
            res = 32'sh7FFFFFFF;
        else if (val < -80'sd2147483648)
            res = 32'sh80000000;
        else
            res = val[31:0];
        return res;
    endfunction

endpackage

/* rtl/dd_odo_if.sv */
// ----------------------------------------------------------------------------
// dd_odo_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface dd_odo_if #(
    parameter type item_t = logic
) ();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/dd_odo_mul.sv */
// ----------------------------------------------------------------------------
// dd_odo_mul
// Shared signed 34x34 multiplier with a registered product.
// ----------------------------------------------------------------------------
module dd_odo_mul (
    input  logic                                 clk,
    input  logic signed [dd_odo_pkg::MUL_W-1:0]  mul_a,
    input  logic signed [dd_odo_pkg::MUL_W-1:0]  mul_b,
    output logic signed [dd_odo_pkg::PROD_W-1:0] prod
);
    import dd_odo_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // product
    always_comb
    begin
        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

/* rtl/dd_odo_cordic.sv */
// ----------------------------------------------------------------------------
// dd_odo_cordic
// Rotation-mode cordic, one micro-rotation per cycle, for sine and cosine
// of a 16-bit binary-angle heading.
// ----------------------------------------------------------------------------
module dd_odo_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [dd_odo_pkg::HEAD_W-1:0]       angle,
    output logic                                busy,
    output logic signed [dd_odo_pkg::MUL_W-1:0] cos_val,
    output logic signed [dd_odo_pkg::MUL_W-1:0] sin_val
);
    import dd_odo_pkg::*;

    localparam int STEP_W = $clog2(STEPS);
    localparam logic signed [MUL_W-1:0] HALF_PI = 34'sd1073741824;
    localparam logic signed [MUL_W-1:0] FULL_PI = 34'sd2147483648;

    logic signed [MUL_W-1:0] x_reg, x_next;
    logic signed [MUL_W-1:0] y_reg, y_next;
    logic signed [MUL_W-1:0] z_reg, z_next;
    logic                    neg_reg, neg_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    busy_reg, busy_next;

    logic signed [MUL_W-1:0] z_init;
    logic signed [MUL_W-1:0] dx;
    logic signed [MUL_W-1:0] dy;
    logic signed [MUL_W-1:0] atan_val;

    // fold into the right half plane, then rotate
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        z_init    = MUL_W'($signed({angle, 16'h0000}));
        dx        = y_reg >>> step_reg;
        dy        = x_reg >>> step_reg;
        atan_val  = $signed({4'b0000, atan_at(5'(step_reg))});
        if (start)
        begin
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            step_next = '0;
            busy_next = 1'b1;
            if (z_init > HALF_PI)
            begin
                z_next   = z_init - FULL_PI;
                neg_next = 1'b1;
            end
            else if (z_init < -HALF_PI)
            begin
                z_next   = z_init + FULL_PI;
                neg_next = 1'b1;
            end
            else
            begin
                z_next   = z_init;
                neg_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_val;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_val;
            end
            if (step_reg == STEP_W'(STEPS - 1))
                busy_next = 1'b0;
            else
                step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
    end

    assign busy    = busy_reg;
    assign cos_val = neg_reg ? -x_reg : x_reg;
    assign sin_val = neg_reg ? -y_reg : y_reg;

endmodule

/* rtl/dd_odo_div.sv */
// ----------------------------------------------------------------------------
// dd_odo_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dd_odo_div #(
    parameter int NUM_W = 49
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [31:0]      den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    logic [32:0] trial;
    logic [32:0] diff;

    // shift in one numerator bit, subtract when it fits
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/dd_odo_sqrt.sv */
// ----------------------------------------------------------------------------
// dd_odo_sqrt
// Digit-by-digit integer square root of a 64-bit value, one root bit per
// cycle.
// ----------------------------------------------------------------------------
module dd_odo_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] rad,
    output logic        busy,
    output logic [31:0] root
);
    logic [63:0] rad_reg, rad_next;
    logic [34:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;

    logic [34:0] rem_sh;
    logic [34:0] trial;

    // bring down two radicand bits, try root*4+1
    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_sh    = {rem_reg[32:0], rad_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
        if (start)
        begin
            rad_next  = rad;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'd31;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[30:0], 1'b0};
            end
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

/* rtl/diff_drive_odometry.sv */
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Fixed-point dead-reckoning odometry for a differential-drive robot, run
// by a sequencer over one shared multiplier, a cordic, a divider and a
// square-root unit.
//
//   channel   dir  beat        handshake
//   in_ch     in   in_item_t   valid/ready
//   out_ch    out  out_item_t  valid/ready
//   cfg       in   32b sep     cfg_we (no wait)
//
// Wheel-speed load and unused action: taken in the idle state, ready stays high.
// Tick: the bit-serial divider (33 + FRACTION_BITS steps) beside the cordic,
// then seven multiplier passes.
// Velocity vectors: two 32-step square roots in turn.
// in_ch.ready is low while an item is worked; a tick result waits in the
// output register, and the block holds before its write until it is free.
// Reset is asynchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module diff_drive_odometry #(
    parameter int CORDIC_STEPS  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    dd_odo_if.sink            in_ch,
    dd_odo_if.source          out_ch
);
    import dd_odo_pkg::*;

    localparam int NUM_W    = 33 + FRACTION_BITS;
    localparam int HEAD_LSB = 2 * FRACTION_BITS + 16;

    seq_state_t state_reg, state_next;

    logic [31:0]        sep_reg, sep_next;
    logic signed [31:0] left_spd_reg, left_spd_next;
    logic signed [31:0] right_spd_reg, right_spd_next;
    logic signed [31:0] prev_lx_reg, prev_lx_next;
    logic signed [31:0] prev_ly_reg, prev_ly_next;
    logic signed [31:0] prev_rx_reg, prev_rx_next;
    logic signed [31:0] prev_ry_reg, prev_ry_next;
    logic signed [31:0] pose_x_reg, pose_x_next;
    logic signed [31:0] pose_y_reg, pose_y_next;
    logic [15:0]        head_reg, head_next;
    logic [31:0]        count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;
    in_item_t           item_reg, item_next;
    logic               wheel_reg, wheel_next;
    logic [63:0]        sq_reg, sq_next;
    logic signed [64:0] dot_reg, dot_next;
    logic signed [31:0] xr_reg, xr_next;
    logic signed [31:0] yr_reg, yr_next;
    logic signed [31:0] tr_reg, tr_next;
    logic               err_reg, err_next;
    logic signed [49:0] p_reg, p_next;
    logic signed [KACC_W-1:0] kacc_reg, kacc_next;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     cor_start, cor_busy;
    logic signed [MUL_W-1:0]  cos_val, sin_val;
    logic                     div_start, div_busy;
    logic [NUM_W-1:0]         div_num, div_quo;
    logic                     sqrt_start, sqrt_busy;
    logic [31:0]              sqrt_root;

    logic                     in_fire;
    logic signed [32:0]       spd_sum, spd_diff;
    logic [32:0]              diff_mag;
    logic signed [31:0]       mean_v;
    logic signed [MUL_W-1:0]  el_op;
    logic signed [31:0]       vec_x, vec_y, vec_px, vec_py;
    logic signed [31:0]       vec_spd;
    logic signed [KACC_W-1:0] head_acc;

    dd_odo_mul u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    dd_odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (head_reg),
        .busy    (cor_busy),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    dd_odo_div #(.NUM_W(NUM_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (sep_reg),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    dd_odo_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (sq_reg),
        .busy  (sqrt_busy),
        .root  (sqrt_root)
    );

    // shared operands
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign spd_sum  = 33'(left_spd_reg) + 33'(right_spd_reg);
    assign spd_diff = 33'(right_spd_reg) - 33'(left_spd_reg);
    assign diff_mag = spd_diff[32] ? 33'(-spd_diff) : 33'(spd_diff);
    assign mean_v   = 32'(spd_sum >>> 1);
    assign div_num  = {diff_mag, {FRACTION_BITS{1'b0}}};
    assign el_op    = $signed({{(MUL_W - ELAPSED_W){1'b0}}, item_reg.elapsed});
    assign vec_x    = wheel_reg ? item_reg.right_vx : item_reg.left_vx;
    assign vec_y    = wheel_reg ? item_reg.right_vy : item_reg.left_vy;
    assign vec_px   = wheel_reg ? prev_rx_reg : prev_lx_reg;
    assign vec_py   = wheel_reg ? prev_ry_reg : prev_ly_reg;
    assign vec_spd  = sqrt_root[31] ? 32'sh7FFFFFFF : $signed(sqrt_root);
    assign head_acc = kacc_reg + (KACC_W'(prod) <<< 25);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.data.action == ACT_TICK)
                        state_next = S_TICK_START;
                    else if (in_ch.data.action == ACT_VECTORS)
                        state_next = S_VEC_SQX;
                end
            end
            S_VEC_SQX:    state_next = S_VEC_SQY;
            S_VEC_SQY:    state_next = S_VEC_DOTX;
            S_VEC_DOTX:   state_next = S_VEC_DOTY;
            S_VEC_DOTY:   state_next = S_VEC_ROOT;
            S_VEC_ROOT:   state_next = S_VEC_WAIT;
            S_VEC_WAIT:
            begin
                if (!sqrt_busy)
                    state_next = wheel_reg ? S_IDLE : S_VEC_SQX;
            end
            S_TICK_START: state_next = S_TICK_WAIT;
            S_TICK_WAIT:
            begin
                if (!cor_busy && !div_busy)
                    state_next = S_MUL_VC;
            end
            S_MUL_VC:     state_next = S_MUL_VS;
            S_MUL_VS:     state_next = S_MUL_XE;
            S_MUL_XE:     state_next = S_MUL_YE;
            S_MUL_YE:     state_next = S_MUL_TE;
            S_MUL_TE:     state_next = S_MUL_KL;
            S_MUL_KL:     state_next = S_MUL_KH;
            S_MUL_KH:     state_next = S_HEAD;
            S_HEAD:       state_next = S_EMIT;
            S_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                    state_next = S_IDLE;
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // datapath and unit control
    always_comb
    begin
        sep_next       = cfg_we ? cfg_wdata : sep_reg;
        left_spd_next  = left_spd_reg;
        right_spd_next = right_spd_reg;
        prev_lx_next   = prev_lx_reg;
        prev_ly_next   = prev_ly_reg;
        prev_rx_next   = prev_rx_reg;
        prev_ry_next   = prev_ry_reg;
        pose_x_next    = pose_x_reg;
        pose_y_next    = pose_y_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;
        item_next      = item_reg;
        wheel_next     = wheel_reg;
        sq_next        = sq_reg;
        dot_next       = dot_reg;
        xr_next        = xr_reg;
        yr_next        = yr_reg;
        tr_next        = tr_reg;
        err_next       = err_reg;
        p_next         = p_reg;
        kacc_next      = kacc_reg;
        mul_a          = '0;
        mul_b          = '0;
        cor_start      = 1'b0;
        div_start      = 1'b0;
        sqrt_start     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    item_next  = in_ch.data;
                    wheel_next = 1'b0;
                    if (in_ch.data.action == ACT_SPEEDS)
                    begin
                        left_spd_next  = in_ch.data.left_speed;
                        right_spd_next = in_ch.data.right_speed;
                    end
                end
            end
            // vector magnitude and sign against the previous vector
            S_VEC_SQX:
            begin
                mul_a = MUL_W'(vec_x);
                mul_b = MUL_W'(vec_x);
            end
            S_VEC_SQY:
            begin
                sq_next = prod[63:0];
                mul_a   = MUL_W'(vec_y);
                mul_b   = MUL_W'(vec_y);
            end
            S_VEC_DOTX:
            begin
                sq_next = sq_reg + prod[63:0];
                mul_a   = MUL_W'(vec_x);
                mul_b   = MUL_W'(vec_px);
            end
            S_VEC_DOTY:
            begin
                dot_next = 65'(prod);
                mul_a    = MUL_W'(vec_y);
                mul_b    = MUL_W'(vec_py);
            end
            S_VEC_ROOT:
            begin
                dot_next   = dot_reg + 65'(prod);
                sqrt_start = 1'b1;
            end
            S_VEC_WAIT:
            begin
                if (!sqrt_busy)
                begin
                    if (wheel_reg)
                    begin
                        right_spd_next = dot_reg[64] ? -vec_spd : vec_spd;
                        prev_lx_next   = item_reg.left_vx;
                        prev_ly_next   = item_reg.left_vy;
                        prev_rx_next   = item_reg.right_vx;
                        prev_ry_next   = item_reg.right_vy;
                    end
                    else
                    begin
                        left_spd_next = dot_reg[64] ? -vec_spd : vec_spd;
                        wheel_next    = 1'b1;
                    end
                end
            end
            // tick: turn rate and sine/cosine in parallel
            S_TICK_START:
            begin
                cor_start = 1'b1;
                div_start = (sep_reg != '0);
            end
            S_TICK_WAIT:
            begin
                if (!cor_busy && !div_busy)
                begin
                    if (sep_reg == '0)
                    begin
                        tr_next  = '0;
                        err_next = 1'b1;
                    end
                    else
                    begin
                        err_next = 1'b0;
                        if (!spd_diff[32])
                            tr_next = (div_quo > NUM_W'(32'h7FFFFFFF)) ?
                                      32'sh7FFFFFFF : $signed(32'(div_quo));
                        else if (div_quo > NUM_W'(32'h80000000))
                            tr_next = 32'sh80000000;
                        else
                            tr_next = -$signed(32'(div_quo));
                    end
                end
            end
            // rates, positions and heading through the shared multiplier
            S_MUL_VC:
            begin
                mul_a = MUL_W'(mean_v);
                mul_b = cos_val;
            end
            S_MUL_VS:
            begin
                xr_next = sat32(KACC_W'(prod >>> 30));
                mul_a   = MUL_W'(mean_v);
                mul_b   = sin_val;
            end
            S_MUL_XE:
            begin
                yr_next = sat32(KACC_W'(prod >>> 30));
                mul_a   = MUL_W'(xr_reg);
                mul_b   = el_op;
            end
            S_MUL_YE:
            begin
                pose_x_next = sat32(KACC_W'(pose_x_reg) +
                                    KACC_W'(prod >>> FRACTION_BITS));
                mul_a       = MUL_W'(yr_reg);
                mul_b       = el_op;
            end
            S_MUL_TE:
            begin
                pose_y_next = sat32(KACC_W'(pose_y_reg) +
                                    KACC_W'(prod >>> FRACTION_BITS));
                mul_a       = MUL_W'(tr_reg);
                mul_b       = el_op;
            end
            S_MUL_KL:
            begin
                p_next = prod[49:0];
                mul_a  = $signed({{(MUL_W - 25){1'b0}}, prod[24:0]});
                mul_b  = RAD_TO_BAM;
            end
            S_MUL_KH:
            begin
                kacc_next = KACC_W'(prod);
                mul_a     = MUL_W'(p_reg >>> 25);
                mul_b     = RAD_TO_BAM;
            end
            S_HEAD:
            begin
                head_next = head_reg + head_acc[HEAD_LSB +: HEAD_W];
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.x_position       = pose_x_reg;
                    out_data_next.y_position       = pose_y_reg;
                    out_data_next.heading          = head_reg;
                    out_data_next.x_rate           = xr_reg;
                    out_data_next.y_rate           = yr_reg;
                    out_data_next.turn_rate        = tr_reg;
                    out_data_next.sequence_res     = count_reg;
                    out_data_next.separation_error = err_reg;
                    count_next                    = count_reg + 1'b1;
                end
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sep_reg       <= 32'h0001_0000;
            left_spd_reg  <= '0;
            right_spd_reg <= '0;
            prev_lx_reg   <= '0;
            prev_ly_reg   <= '0;
            prev_rx_reg   <= '0;
            prev_ry_reg   <= '0;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            wheel_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sep_reg       <= sep_next;
            left_spd_reg  <= left_spd_next;
            right_spd_reg <= right_spd_next;
            prev_lx_reg   <= prev_lx_next;
            prev_ly_reg   <= prev_ly_next;
            prev_rx_reg   <= prev_rx_next;
            prev_ry_reg   <= prev_ry_next;
            pose_x_reg    <= pose_x_next;
            pose_y_reg    <= pose_y_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            wheel_reg     <= wheel_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        item_reg     <= item_next;
        sq_reg       <= sq_next;
        dot_reg      <= dot_next;
        xr_reg       <= xr_next;
        yr_reg       <= yr_next;
        tr_reg       <= tr_next;
        err_reg      <= err_next;
        p_reg        <= p_next;
        kacc_reg     <= kacc_next;
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

endmodule

/* rtl/dd_odo_check.sv */
// ----------------------------------------------------------------------------
// dd_odo_check
// Port-level assertions for the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
module dd_odo_check (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [1:0]            in_action,
    input logic                  out_valid,
    input logic                  out_ready,
    input dd_odo_pkg::out_item_t out_data
);
    import dd_odo_pkg::*;

    // long actions drop ready right after their beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_action == ACT_TICK || in_action == ACT_VECTORS)
        |=> !in_ready)
        else $error("ready stayed high after a tick or vector beat");

    // a new result comes out of a busy tick
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a tick in progress");

    // zero separation forces zero turn rate
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.separation_error |-> out_data.turn_rate == 0)
        else $error("separation error with nonzero turn rate");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

endmodule

bind diff_drive_odometry dd_odo_check u_dd_odo_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.data.action),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

/* tb/diff_drive_odometry_tb.sv */
// ----------------------------------------------------------------------------
// diff_drive_odometry_tb
// Self-checking bench for the differential-drive odometry block. A local
// fixed-point model of the pose integrator predicts every tick result. The
// run covers directed corner cases and a long output stall first, then
// constrained-free random traffic under three idle mixes with full drain pauses.
// ----------------------------------------------------------------------------
module diff_drive_odometry_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dd_odo_pkg::*;

    localparam int          WATCHDOG_LIMIT = 6000;
    localparam int          SETTLE_CYCLES  = 150;
    localparam int          HOLD_CYCLES    = 500;
    localparam logic [31:0] SEP_ONE        = 32'h0001_0000;
    localparam logic [1:0]  ACT_IGNORED    = 2'd3;

    // arctangent of 2^-i as a 32-bit binary angle
    localparam longint ATAN_BAM [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };
    localparam int     ROT_STEPS  = 16;
    localparam int     FRAC       = 16;
    localparam longint GAIN_Q30   = 64'h26DD3B6A;
    localparam longint RAD_TO_BIN = 64'h28BE60DC;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;

    dd_odo_if #(.item_t(in_item_t))  in_ch ();
    dd_odo_if #(.item_t(out_item_t)) out_ch ();

    diff_drive_odometry dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #2 clk = ~clk;

    // odometry model state
    logic [31:0] sep_q16;
    int          left_spd, right_spd;
    int          prev_l [2];
    int          prev_r [2];
    int          pose_x_q, pose_y_q;
    logic [15:0] pose_hdg;
    logic [31:0] pose_count;

    out_item_t   expected_poses [$];
    int          mismatches = 0;
    int          poses_seen = 0;
    int          items_sent = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    function automatic int clamp32(longint val);
        if (val > 64'sd2147483647)
            return 32'h7FFFFFFF;
        if (val < -64'sd2147483648)
            return 32'h80000000;
        return int'(val);
    endfunction

    // rotation-mode cordic on the folded heading
    task automatic sin_cos(input logic [15:0] hdg, output longint cval, output longint sval);
        longint z;
        longint xv;
        longint yv;
        longint dx;
        longint dy;
        bit     flip;
        z = longint'(hdg) * 65536;
        xv = GAIN_Q30;
        yv = 0;
        flip = 1'b0;
        if (z >= (64'sd1 <<< 31))
            z = z - (64'sd1 <<< 32);
        if (z > (64'sd1 <<< 30))
        begin
            z = z - (64'sd1 <<< 31);
            flip = 1'b1;
        end
        else if (z < -(64'sd1 <<< 30))
        begin
            z = z + (64'sd1 <<< 31);
            flip = 1'b1;
        end
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (z >= 0)
            begin
                xv = xv - dx;
                yv = yv + dy;
                z = z - ATAN_BAM[i];
            end
            else
            begin
                xv = xv + dx;
                yv = yv - dy;
                z = z + ATAN_BAM[i];
            end
        end
        cval = flip ? -xv : xv;
        sval = flip ? -yv : yv;
    endtask

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'h1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // magnitude of a wheel vector, signed against the previous vector
    function automatic int wheel_speed(longint vx, longint vy, longint px, longint py);
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned mag;
        longint          spd;
        ax = (vx < 0) ? -vx : vx;
        ay = (vy < 0) ? -vy : vy;
        mag = int_sqrt(ax * ax + ay * ay);
        spd = (mag > 64'd2147483647) ? 64'sd2147483647 : longint'(mag);
        if (vx * px < -(vy * py))
            spd = -spd;
        return int'(spd);
    endfunction

    // advance the model by one accepted beat
    task automatic odometry_step(input in_item_t item);
        longint    el;
        longint    vmean;
        longint    diff;
        longint    cval;
        longint    sval;
        longint    prod;
        longint    p_hi;
        longint    p_lo;
        longint    acc;
        int        xr;
        int        yr;
        int        tr;
        out_item_t pose;
        case (item.action)
            ACT_SPEEDS:
            begin
                left_spd = item.left_speed;
                right_spd = item.right_speed;
            end
            ACT_VECTORS:
            begin
                left_spd = wheel_speed(item.left_vx, item.left_vy, prev_l[0], prev_l[1]);
                right_spd = wheel_speed(item.right_vx, item.right_vy, prev_r[0], prev_r[1]);
                prev_l[0] = item.left_vx;
                prev_l[1] = item.left_vy;
                prev_r[0] = item.right_vx;
                prev_r[1] = item.right_vy;
            end
            ACT_TICK:
            begin
                el = longint'(item.elapsed);
                vmean = (longint'(left_spd) + longint'(right_spd)) >>> 1;
                diff = longint'(right_spd) - longint'(left_spd);
                pose.separation_error = (sep_q16 == 0);
                if (sep_q16 == 0)
                    tr = 0;
                else
                    tr = clamp32((diff * 65536) / longint'({32'b0, sep_q16}));
                sin_cos(pose_hdg, cval, sval);
                xr = clamp32((vmean * cval) >>> 30);
                yr = clamp32((vmean * sval) >>> 30);
                pose_x_q = clamp32(longint'(pose_x_q) + ((longint'(xr) * el) >>> FRAC));
                pose_y_q = clamp32(longint'(pose_y_q) + ((longint'(yr) * el) >>> FRAC));
                prod = longint'(tr) * el;
                p_hi = prod >>> 16;
                p_lo = prod - p_hi * 65536;
                acc = p_hi * RAD_TO_BIN + ((p_lo * RAD_TO_BIN) >>> 16);
                acc = acc >>> (2 * FRAC);
                pose_hdg = pose_hdg + acc[15:0];
                pose.x_position = pose_x_q;
                pose.y_position = pose_y_q;
                pose.heading = pose_hdg;
                pose.x_rate = xr;
                pose.y_rate = yr;
                pose.turn_rate = tr;
                pose.sequence_res = pose_count;
                pose_count = pose_count + 1;
                expected_poses.push_back(pose);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch pose %0d %s: got %0h want %0h", poses_seen, what, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_poses.size() == 0)
                report("unexpected beat", got.sequence_res, 0);
            else
            begin
                want = expected_poses.pop_front();
                if (got.x_position !== want.x_position)
                    report("x_position", got.x_position, want.x_position);
                if (got.y_position !== want.y_position)
                    report("y_position", got.y_position, want.y_position);
                if (got.heading !== want.heading)
                    report("heading", got.heading, want.heading);
                if (got.x_rate !== want.x_rate)
                    report("x_rate", got.x_rate, want.x_rate);
                if (got.y_rate !== want.y_rate)
                    report("y_rate", got.y_rate, want.y_rate);
                if (got.turn_rate !== want.turn_rate)
                    report("turn_rate", got.turn_rate, want.turn_rate);
                if (got.sequence_res !== want.sequence_res)
                    report("sequence_res", got.sequence_res, want.sequence_res);
                if (got.separation_error !== want.separation_error)
                    report("separation_error", got.separation_error,
                           want.separation_error);
            end
            poses_seen++;
        end
    end

    // output ready with random stalls and an occasional long hold
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d poses pending", expected_poses.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(input in_item_t item);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= item;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        odometry_step(item);
        items_sent++;
    endtask

    // stop offering, wait for every pose, then let a vector load finish
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_poses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_separation(input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sep_q16 = val;
    endtask

    function automatic in_item_t make_item(logic [1:0] act);
        in_item_t item;
        item.action = act;
        item.left_speed = $urandom;
        item.right_speed = $urandom;
        item.left_vx = $urandom;
        item.left_vy = $urandom;
        item.right_vx = $urandom;
        item.right_vy = $urandom;
        item.elapsed = 18'($urandom);
        return item;
    endfunction

    function automatic in_item_t tick_item(logic [17:0] el);
        in_item_t item;
        item = make_item(ACT_TICK);
        item.elapsed = el;
        return item;
    endfunction

    function automatic in_item_t speeds_item(int lsp, int rsp);
        in_item_t item;
        item = make_item(ACT_SPEEDS);
        item.left_speed = lsp;
        item.right_speed = rsp;
        return item;
    endfunction

    function automatic in_item_t vectors_item(int lx, int ly, int rx, int ry);
        in_item_t item;
        item = make_item(ACT_VECTORS);
        item.left_vx = lx;
        item.left_vy = ly;
        item.right_vx = rx;
        item.right_vy = ry;
        return item;
    endfunction

    // mostly modest speeds so the pose does not pin at the rails
    function automatic int rand_speed();
        if ($urandom_range(3) == 0)
            return $urandom;
        return $signed($urandom_range(20 << 16)) - (10 << 16);
    endfunction

    function automatic logic [17:0] rand_elapsed();
        if ($urandom_range(4) == 0)
            return 18'($urandom);
        return 18'($urandom_range(16'h2000));
    endfunction

    // zero speeds from reset, then wheel speed extremes
    task automatic test_speed_extremes();
        send_item(tick_item(18'h3FFFF));
        send_item(speeds_item(32'h7FFFFFFF, 32'h7FFFFFFF));
        send_item(tick_item(18'h3FFFF));
        send_item(speeds_item(32'h80000000, 32'h80000000));
        send_item(tick_item(18'h3FFFF));
        send_item(speeds_item(32'h80000000, 32'h7FFFFFFF));
        send_item(tick_item(18'h00001));
        send_item(speeds_item(32'h7FFFFFFF, 32'h80000000));
        send_item(tick_item(18'h00000));
        drain();
    endtask

    // zero, smallest and largest wheel separation
    task automatic test_separation();
        logic [31:0] seps [3] = '{32'h0, 32'h1, 32'hFFFFFFFF};
        foreach (seps[i])
        begin
            write_separation(seps[i]);
            send_item(speeds_item(-(3 << 16), 5 << 16));
            send_item(tick_item(18'h10000));
            drain();
        end
        write_separation(SEP_ONE);
    endtask

    // first vector, same direction, reversed, largest magnitude, zero
    task automatic test_vectors();
        send_item(vectors_item(2 << 16, 1 << 16, -(1 << 16), 3 << 16));
        send_item(tick_item(18'h08000));
        send_item(vectors_item(3 << 16, 2 << 16, -(2 << 16), 2 << 16));
        send_item(vectors_item(-(3 << 16), -(2 << 16), 2 << 16, -(2 << 16)));
        send_item(tick_item(18'h08000));
        send_item(vectors_item(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000));
        send_item(tick_item(18'h3FFFF));
        send_item(vectors_item(0, 0, 0, 0));
        send_item(tick_item(18'h3FFFF));
        drain();
    endtask

    // unused selector must leave the pose alone
    task automatic test_ignored_action();
        send_item(make_item(ACT_IGNORED));
        send_item(make_item(ACT_IGNORED));
        send_item(tick_item(18'h04000));
        drain();
    endtask

    // long output hold while the sender keeps offering
    task automatic test_output_stall();
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 3 == 0)
                send_item(speeds_item(rand_speed(), rand_speed()));
            send_item(tick_item(rand_elapsed()));
        end
        drain();
    endtask

    // well-formed load then tick sequences with some noise
    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
        int          sel;
        int          lx;
        int          ly;
        int          rx;
        int          ry;
        logic [31:0] sep_pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 40)
                send_item(tick_item(rand_elapsed()));
            else if (sel < 65)
                send_item(speeds_item(rand_speed(), rand_speed()));
            else if (sel < 92)
            begin
                lx = rand_speed();
                ly = rand_speed();
                rx = rand_speed();
                ry = rand_speed();
                // sometimes reverse the last vectors to flip the sign
                if ($urandom_range(2) == 0)
                begin
                    lx = -prev_l[0];
                    ly = -prev_l[1];
                end
                if ($urandom_range(2) == 0)
                begin
                    rx = -prev_r[0];
                    ry = -prev_r[1];
                end
                send_item(vectors_item(lx, ly, rx, ry));
            end
            else if (sel < 96)
                send_item(make_item(ACT_IGNORED));
            else
                send_item(make_item(ACT_TICK));
            // occasional pause until all poses are out, with a new separation
            if ($urandom_range(99) == 0)
            begin
                drain();
                case ($urandom_range(3))
                    0:       sep_pick = 32'h0;
                    1:       sep_pick = $urandom;
                    default: sep_pick = $urandom_range(1 << 16, 4 << 16);
                endcase
                write_separation(sep_pick);
            end
        end
        drain();
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        sep_q16 = SEP_ONE;
        left_spd = 0;
        right_spd = 0;
        prev_l = '{0, 0};
        prev_r = '{0, 0};
        pose_x_q = 0;
        pose_y_q = 0;
        pose_hdg = '0;
        pose_count = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_speed_extremes();
        test_separation();
        test_vectors();
        test_ignored_action();
        test_output_stall();
        test_random_traffic(300, 19, 78);
        test_random_traffic(300, 78, 19);
        test_random_traffic(300, 0, 0);
        write_separation(SEP_ONE);
        test_random_traffic(20, 0, 0);

        if (expected_poses.size() != 0)
            report("poses never delivered", expected_poses.size(), 0);
        $display("sent %0d beats, checked %0d poses across speed, vector, separation",
                 items_sent, poses_seen);
        $display("and idle mixes including a long output stall; %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
